// File: rtl/rau_pkg.sv
`default_nettype none

package rau_pkg;

  // Word width of the arithmetic; operands are the low bits of each field, sign extended.
  localparam int WordWidth  = 32;
  localparam int FieldWidth = 32;
  localparam int MulWidth   = WordWidth + 1;
  localparam int ProdWidth  = 2 * MulWidth;
  localparam int EngWidth   = 2 * WordWidth;
  localparam int ShiftWidth = $clog2(EngWidth);

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_SUB    = 3'd1,
    OP_MUL    = 3'd2,
    OP_DIV    = 3'd3,
    OP_CMP    = 3'd4,
    OP_REDUCE = 3'd5
  } rau_op_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_ZERO_DEN = 2'd1,
    STAT_RANGE    = 2'd2
  } rau_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_MUL,
    S_USE,
    S_GCD,
    S_DONE
  } rau_state_e;

  typedef enum logic [2:0] {
    EN_IDLE,
    EN_COMMON,
    EN_MAIN,
    EN_DIVA,
    EN_DIVB,
    EN_DONE
  } rau_eng_state_e;

  typedef struct packed {
    logic [2:0]                   operation;
    logic signed [FieldWidth-1:0] left_num;
    logic signed [FieldWidth-1:0] left_den;
    logic signed [FieldWidth-1:0] right_num;
    logic signed [FieldWidth-1:0] right_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [FieldWidth-1:0] result_num;
    logic signed [FieldWidth-1:0] result_den;
    logic                         is_equal;
    logic                         is_less;
    logic [1:0]                   status;
  } rau_out_t;

  // Request to the GCD and exact divide engine.
  typedef struct packed {
    logic                start;
    logic [EngWidth-1:0] a;
    logic [EngWidth-1:0] b;
  } rau_eng_req_t;

  // Engine answer: a and b divided by their greatest common divisor.
  typedef struct packed {
    logic                done;
    logic [EngWidth-1:0] qa;
    logic [EngWidth-1:0] qb;
  } rau_eng_rsp_t;

endpackage

`default_nettype wire

// File: rtl/rational_arithmetic_unit_top.sv
// Rational arithmetic unit: one beat in carries an operation and two signed fractions, one
// beat out carries the result fraction, the compare flags and a status. The unit works on
// one beat at a time and stalls its input until the work is done; the output register lets
// the next beat enter while the last result waits. Cost is set by the shared GCD/divide
// engine, which runs one binary GCD step a cycle (each step drops at least one operand bit)
// and then two restoring divides by the GCD. Add and subtract make two engine passes;
// multiply, divide and reduce make one; compare, a zero denominator and an unused
// operation code use none.
`default_nettype none

module rational_arithmetic_unit_top import rau_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  rau_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output rau_out_t out_data_o
);

  function automatic logic [WordWidth-1:0] mag_w(input logic [WordWidth-1:0] v);
    return v[WordWidth-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [FieldWidth-1:0] sext_w(input logic [WordWidth-1:0] v);
    return FieldWidth'($signed(v));
  endfunction

  rau_state_e                state_q, state_d;
  logic [2:0]                op_q, op_d;
  logic signed [WordWidth-1:0] ln_q, ln_d, ld_q, ld_d, rn_q, rn_d, rd_q, rd_d;
  logic [2:0]                mcnt_q, mcnt_d;
  logic signed [ProdWidth-1:0] p_q [4];
  logic signed [ProdWidth-1:0] p_d [4];
  logic signed [MulWidth-1:0] ka_q, ka_d, kb_q, kb_d;
  logic                      neg_q, neg_d, pass_q, pass_d;
  rau_out_t                  res_q, res_d, out_q, out_d;
  logic                      out_valid_q, out_valid_d;

  logic                      acc;
  rau_eng_req_t              eng_req;
  rau_eng_rsp_t              eng_rsp;
  logic signed [MulWidth-1:0]  mul_a, mul_b;
  logic signed [ProdWidth-1:0] prod;

  assign acc        = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  // Operand views.
  logic [WordWidth-1:0]       rn_eff;
  logic                       ld_zero, rd_zero, rn_zero, is_div;
  logic signed [MulWidth-1:0] ln_m, ld_m, rn_m, rd_m, rne_m, ldmag_m, rdmag_m;
  logic signed [MulWidth-1:0] ca_m, cc_m, k1_m, k2_m;
  logic [2:0]                 nprod, widx;

  assign rn_eff  = (op_q == OP_SUB) ? (~rn_q + 1'b1) : rn_q;
  assign ld_zero = (ld_q == '0);
  assign rd_zero = (rd_q == '0);
  assign rn_zero = (rn_q == '0);
  assign is_div  = (op_q == OP_DIV);
  assign ln_m    = MulWidth'(ln_q);
  assign ld_m    = MulWidth'(ld_q);
  assign rn_m    = MulWidth'(rn_q);
  assign rd_m    = MulWidth'(rd_q);
  assign rne_m   = MulWidth'($signed(rn_eff));
  assign ldmag_m = {1'b0, mag_w(ld_q)};
  assign rdmag_m = {1'b0, mag_w(rd_q)};
  assign ca_m    = ld_q[WordWidth-1] ? -ln_m : ln_m;
  assign cc_m    = rd_q[WordWidth-1] ? -rn_m : rn_m;
  assign k1_m    = ld_q[WordWidth-1] ? -kb_q : kb_q;
  assign k2_m    = rd_q[WordWidth-1] ? -ka_q : ka_q;
  assign widx    = mcnt_q - 3'd1;

  // Number of products each operation needs.
  always_comb begin
    if (op_q == OP_ADD || op_q == OP_SUB) begin
      nprod = 3'd3;
    end else if (op_q == OP_CMP) begin
      nprod = 3'd4;
    end else begin
      nprod = 3'd2;
    end
  end

  // Multiplier operand selection, one product per cycle.
  always_comb begin
    mul_a = ln_m;
    mul_b = rd_m;
    if (op_q == OP_ADD || op_q == OP_SUB) begin
      unique case (mcnt_q[1:0])
        2'd0:    begin mul_a = ka_q;  mul_b = rdmag_m; end
        2'd1:    begin mul_a = ln_m;  mul_b = k1_m;    end
        default: begin mul_a = rne_m; mul_b = k2_m;    end
      endcase
    end else if (op_q == OP_CMP) begin
      unique case (mcnt_q[1:0])
        2'd0:    begin mul_a = ln_m; mul_b = rd_m;    end
        2'd1:    begin mul_a = ld_m; mul_b = rn_m;    end
        2'd2:    begin mul_a = ca_m; mul_b = rdmag_m; end
        default: begin mul_a = cc_m; mul_b = ldmag_m; end
      endcase
    end else begin
      if (mcnt_q[1:0] == 2'd0) begin
        mul_a = ln_m;
        mul_b = is_div ? rd_m : rn_m;
      end else begin
        mul_a = ld_m;
        mul_b = is_div ? rn_m : rd_m;
      end
    end
  end

  rau_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  rau_gcd_div u_eng (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (eng_req),
    .rsp_o  (eng_rsp)
  );

  // Values derived from the stored products and the engine answer.
  logic [ProdWidth-1:0] pabs0, pabs1, nsum;
  logic [WordWidth-1:0] n_w;
  logic [EngWidth-1:0]  qsigned;
  logic [WordWidth-1:0] qnum, qden;

  assign pabs0   = p_q[0][ProdWidth-1] ? -p_q[0] : p_q[0];
  assign pabs1   = p_q[1][ProdWidth-1] ? -p_q[1] : p_q[1];
  assign nsum    = p_q[1] + p_q[2];
  assign n_w     = nsum[WordWidth-1:0];
  assign qsigned = neg_q ? -eng_rsp.qa : eng_rsp.qa;
  assign qnum    = qsigned[WordWidth-1:0];
  assign qden    = eng_rsp.qb[WordWidth-1:0];

  // Main sequencer.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    ln_d        = ln_q;
    ld_d        = ld_q;
    rn_d        = rn_q;
    rd_d        = rd_q;
    mcnt_d      = mcnt_q;
    p_d         = p_q;
    ka_d        = ka_q;
    kb_d        = kb_q;
    neg_d       = neg_q;
    pass_d      = pass_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    eng_req     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          op_d    = in_data_i.operation;
          ln_d    = in_data_i.left_num[WordWidth-1:0];
          ld_d    = in_data_i.left_den[WordWidth-1:0];
          rn_d    = in_data_i.right_num[WordWidth-1:0];
          rd_d    = in_data_i.right_den[WordWidth-1:0];
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_d.result_num = '0;
        res_d.result_den = FieldWidth'(1);
        res_d.is_equal   = 1'b0;
        res_d.is_less    = 1'b0;
        res_d.status     = STAT_OK;
        mcnt_d           = '0;
        if (op_q == OP_ADD || op_q == OP_SUB) begin
          if (ld_zero || rd_zero) begin
            res_d.status = STAT_ZERO_DEN;
            state_d      = S_DONE;
          end else begin
            eng_req.start = 1'b1;
            eng_req.a     = EngWidth'(mag_w(ld_q));
            eng_req.b     = EngWidth'(mag_w(rd_q));
            pass_d        = 1'b0;
            state_d       = S_GCD;
          end
        end else if (op_q == OP_MUL || op_q == OP_CMP) begin
          if (ld_zero || rd_zero) begin
            res_d.status = STAT_ZERO_DEN;
            state_d      = S_DONE;
          end else begin
            state_d = S_MUL;
          end
        end else if (op_q == OP_DIV) begin
          if (ld_zero || rd_zero || rn_zero) begin
            res_d.status = STAT_ZERO_DEN;
            state_d      = S_DONE;
          end else begin
            state_d = S_MUL;
          end
        end else if (op_q == OP_REDUCE) begin
          if (ld_zero) begin
            res_d.status = STAT_ZERO_DEN;
            state_d      = S_DONE;
          end else begin
            eng_req.start = 1'b1;
            eng_req.a     = EngWidth'(mag_w(ln_q));
            eng_req.b     = EngWidth'(mag_w(ld_q));
            neg_d         = ln_q[WordWidth-1] ^ ld_q[WordWidth-1];
            pass_d        = 1'b1;
            state_d       = S_GCD;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_MUL: begin
        // The product of the previous count arrives from the multiplier register.
        mcnt_d = mcnt_q + 3'd1;
        if (mcnt_q != 3'd0) begin
          p_d[widx[1:0]] = prod;
        end
        if (mcnt_q == nprod) begin
          state_d = S_USE;
        end
      end
      S_USE: begin
        if (op_q == OP_CMP) begin
          res_d.is_equal = (p_q[0] == p_q[1]);
          res_d.is_less  = (p_q[2] < p_q[3]);
          state_d        = S_DONE;
        end else if (op_q == OP_ADD || op_q == OP_SUB) begin
          // The common multiple must fit a positive word.
          if (p_q[0][ProdWidth-1:WordWidth-1] != '0) begin
            res_d.status = STAT_RANGE;
            state_d      = S_DONE;
          end else begin
            eng_req.start = 1'b1;
            eng_req.a     = EngWidth'(mag_w(n_w));
            eng_req.b     = p_q[0][EngWidth-1:0];
            neg_d         = n_w[WordWidth-1];
            pass_d        = 1'b1;
            state_d       = S_GCD;
          end
        end else begin
          eng_req.start = 1'b1;
          eng_req.a     = pabs0[EngWidth-1:0];
          eng_req.b     = pabs1[EngWidth-1:0];
          neg_d         = p_q[0][ProdWidth-1] ^ p_q[1][ProdWidth-1];
          pass_d        = 1'b1;
          state_d       = S_GCD;
        end
      end
      S_GCD: begin
        if (eng_rsp.done) begin
          if (!pass_q) begin
            // First add pass: the denominators divided by their GCD scale the numerators.
            ka_d    = eng_rsp.qa[MulWidth-1:0];
            kb_d    = eng_rsp.qb[MulWidth-1:0];
            mcnt_d  = '0;
            state_d = S_MUL;
          end else begin
            if ((op_q == OP_MUL || op_q == OP_DIV) && qden == '0) begin
              res_d.status = STAT_ZERO_DEN;
            end else begin
              res_d.result_num = sext_w(qnum);
              res_d.result_den = sext_w(qden);
            end
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    ln_q   <= ln_d;
    ld_q   <= ld_d;
    rn_q   <= rn_d;
    rd_q   <= rd_d;
    mcnt_q <= mcnt_d;
    p_q    <= p_d;
    ka_q   <= ka_d;
    kb_q   <= kb_d;
    neg_q  <= neg_d;
    pass_q <= pass_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Once a beat is taken the unit is busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> in_stall_o)
    else $error("input taken without going busy");

  // An error beat carries the fraction zero over one.
  a_error_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != STAT_OK |->
      out_data_o.result_num == '0 && out_data_o.result_den == FieldWidth'(1))
    else $error("error beat with a nonzero fraction");

  // Equal and less are never both set.
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.is_equal && out_data_o.is_less))
    else $error("equal and less set together");

endmodule

`default_nettype wire

// File: rtl/rau_mul.sv
`default_nettype none

module rau_mul import rau_pkg::*; (
  input  logic                        clk_i,
  input  logic signed [MulWidth-1:0]  a_i,
  input  logic signed [MulWidth-1:0]  b_i,
  output logic signed [ProdWidth-1:0] p_o
);

  logic signed [ProdWidth-1:0] p_q;

  // Signed product, registered before anything uses it.
  always_ff @(posedge clk_i) begin
    p_q <= ProdWidth'(a_i) * ProdWidth'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// File: rtl/rau_gcd_div.sv
`default_nettype none

module rau_gcd_div import rau_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  rau_eng_req_t req_i,
  output rau_eng_rsp_t rsp_o
);

  rau_eng_state_e        state_q, state_d;
  logic [EngWidth-1:0]   x_q, x_d, y_q, y_d;
  logic [EngWidth-1:0]   sa_q, sa_d, sb_q, sb_d;
  logic [EngWidth-1:0]   g_q, g_d;
  logic [EngWidth-1:0]   dvd_q, dvd_d, rem_q, rem_d, quo_q, quo_d, qa_q, qa_d;
  logic [ShiftWidth-1:0] k_q, k_d, cnt_q, cnt_d;

  // The one shared subtractor, used by the GCD steps and by the divide steps.
  logic [EngWidth:0]   sub_a, sub_b;
  logic [EngWidth+1:0] diff;
  logic                sub_neg;
  logic [EngWidth-1:0] negd;

  assign diff    = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_neg = diff[EngWidth+1];
  assign negd    = ~diff[EngWidth-1:0] + {{(EngWidth-1){1'b0}}, 1'b1};

  always_comb begin
    if (state_q == EN_DIVA || state_q == EN_DIVB) begin
      sub_a = {rem_q, dvd_q[EngWidth-1]};
      sub_b = {1'b0, g_q};
    end else begin
      sub_a = {1'b0, x_q};
      sub_b = {1'b0, y_q};
    end
  end

  // Sequencer: binary GCD one step a cycle, then two restoring divides by the GCD.
  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    y_d     = y_q;
    sa_d    = sa_q;
    sb_d    = sb_q;
    g_d     = g_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    qa_d    = qa_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      EN_IDLE: begin
        if (req_i.start) begin
          x_d     = req_i.a;
          y_d     = req_i.b;
          sa_d    = req_i.a;
          sb_d    = req_i.b;
          k_d     = '0;
          state_d = EN_COMMON;
        end
      end
      EN_COMMON: begin
        // Strip the common factors of two and count them.
        if (x_q[0] || y_q[0] || x_q == '0 || y_q == '0) begin
          state_d = EN_MAIN;
        end else begin
          x_d = x_q >> 1;
          y_d = y_q >> 1;
          k_d = k_q + 1'b1;
        end
      end
      EN_MAIN: begin
        priority if (x_q == '0 || y_q == '0) begin
          g_d     = (x_q == '0) ? (y_q << k_q) : (x_q << k_q);
          rem_d   = '0;
          dvd_d   = sa_q;
          cnt_d   = '0;
          state_d = EN_DIVA;
        end else if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (!sub_neg) begin
          // Both odd: the difference is even, halve it at once.
          x_d = {1'b0, diff[EngWidth-1:1]};
        end else begin
          y_d = {1'b0, negd[EngWidth-1:1]};
        end
      end
      EN_DIVA, EN_DIVB: begin
        // One quotient bit a cycle.
        dvd_d = dvd_q << 1;
        if (!sub_neg) begin
          rem_d = diff[EngWidth-1:0];
          quo_d = {quo_q[EngWidth-2:0], 1'b1};
        end else begin
          rem_d = sub_a[EngWidth-1:0];
          quo_d = {quo_q[EngWidth-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ShiftWidth'(EngWidth - 1)) begin
          cnt_d = '0;
          if (state_q == EN_DIVA) begin
            qa_d    = quo_d;
            rem_d   = '0;
            dvd_d   = sb_q;
            state_d = EN_DIVB;
          end else begin
            state_d = EN_DONE;
          end
        end
      end
      EN_DONE: begin
        state_d = EN_IDLE;
      end
      default: begin
        state_d = EN_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EN_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    sa_q  <= sa_d;
    sb_q  <= sb_d;
    g_q   <= g_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    qa_q  <= qa_d;
    k_q   <= k_d;
    cnt_q <= cnt_d;
  end

  assign rsp_o.done = (state_q == EN_DONE);
  assign rsp_o.qa   = qa_q;
  assign rsp_o.qb   = quo_q;

  // A new request only arrives while the engine is free.
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == EN_IDLE)
    else $error("engine started while busy");

  // The divisor of the division phase is never zero.
  a_gcd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == EN_DIVA |-> g_q != '0)
    else $error("zero GCD reached the divider");

  // The done pulse lasts a single cycle.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == EN_DONE |=> state_q == EN_IDLE)
    else $error("engine stayed in done");

endmodule

`default_nettype wire
